[sv/nnis_pkg.sv]
// Shared types and constants for the nearest-neighbor image scaler.
// Holds geometry, widths, register codes and the queue entry format.
// No dependencies; imported by every module of the scaler.
`default_nettype none

package nnis_pkg;

    // Source store geometry and fixed-point format
    localparam int MAX_SRC_W = 128;
    localparam int MAX_SRC_H = 128;
    localparam int FRAC_BITS = 16;

    // Fixed field widths of the ports
    localparam int SIZE_W  = 8;
    localparam int OUT_W   = 12;
    localparam int DEST_W  = 13;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int IDX_W   = 14;

    // Derived widths
    localparam int SW_W   = $clog2(MAX_SRC_W + 1);
    localparam int SH_W   = $clog2(MAX_SRC_H + 1);
    localparam int SZ_W   = (SW_W > SH_W) ? SW_W : SH_W;
    localparam int SX_W   = (MAX_SRC_W > 1) ? $clog2(MAX_SRC_W) : 1;
    localparam int SY_W   = (MAX_SRC_H > 1) ? $clog2(MAX_SRC_H) : 1;
    localparam int STEP_W = SZ_W + FRAC_BITS;
    localparam int ACC_W  = OUT_W + STEP_W;
    localparam int INT_W  = ACC_W - FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(STEP_W + 1);

    localparam int STORE_DEPTH = MAX_SRC_W * MAX_SRC_H;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((IDX_W + COLOR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * DEST_W + COLOR_W + 7) / 8) * 8;

    // Configuration port
    localparam int REG_W     = 12;
    localparam int REG_IDX_W = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SRC_W = 3'd0,
        REG_SRC_H = 3'd1,
        REG_OUT_W = 3'd2,
        REG_OUT_H = 3'd3,
        REG_ORG_X = 3'd4,
        REG_ORG_Y = 3'd5
    } t_reg_idx;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EMIT = 1'b1
    } t_req;

    // Effective geometry after size clamping
    typedef struct packed {
        logic [SW_W-1:0]  src_w;
        logic [SH_W-1:0]  src_h;
        logic [OUT_W-1:0] out_w;
        logic [OUT_W-1:0] out_h;
        logic [OUT_W-1:0] org_x;
        logic [OUT_W-1:0] org_y;
    } t_geom;

    // One classified operation
    typedef struct packed {
        t_req               kind;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic [SX_W-1:0]    sx;
        logic [SY_W-1:0]    sy;
        logic [DEST_W-1:0]  dest_x;
        logic [DEST_W-1:0]  dest_y;
        logic               last;
    } t_op;

endpackage

`default_nettype wire

[sv/nearest_neighbor_image_scaler_unit.sv]
// Top level of the nearest-neighbor image scaler: configuration registers,
// step dividers, front end, queue and back end. Depends on nnis_pkg and all
// nnis_* modules.
//
// The scaler holds a 128 x 128 source bitmap (24-bit pixels, bottom row
// first). A beat with tuser low loads one pixel at its packed index; a beat
// with tuser high produces the next scaled pixel in raster order, with its
// destination coordinates, RGB color and tlast on the frame's last pixel.
// Loads and emits are taken one per cycle while the queue is not full and
// the input is not held off, and leave in order; an emit's result passes
// the queue, the address stage and the registered store read. A write to any
// of the six registers restarts the frame and reruns the two 8.16 step
// divisions, one quotient bit per cycle; the input is held off until they end.
`default_nettype none

module nearest_neighbor_image_scaler_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [nnis_pkg::REG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [nnis_pkg::REG_W-1:0]          i_cfg_wdata,
    // Input stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: src_index[13:0], blue[21:14], green[29:22], red[37:30], zero pad
    input  wire logic [nnis_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser: req_type (0 load, 1 emit)
    input  wire logic                                i_s_axis_tuser,
    // Output stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: dest_x[12:0], dest_y[25:13], color[49:26], zero pad
    output logic [nnis_pkg::M_TDATA_W-1:0]           o_m_axis_tdata,
    // tlast: frame_end
    output logic                                     o_m_axis_tlast
);
    import nnis_pkg::*;

    logic [SIZE_W-1:0] r_src_w;
    logic [SIZE_W-1:0] r_src_h;
    logic [OUT_W-1:0]  r_out_w;
    logic [OUT_W-1:0]  r_out_h;
    logic [OUT_W-1:0]  r_org_x;
    logic [OUT_W-1:0]  r_org_y;
    logic              r_div_start;

    logic              cfg_hit;
    t_geom             geom;
    logic [STEP_W-1:0] col_step;
    logic [STEP_W-1:0] row_step;
    logic              col_busy;
    logic              row_busy;
    logic              hold;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_op               front_op;
    t_op               queue_op;

    // Decode register index
    always_comb begin
        case (t_reg_idx'(i_cfg_addr))
            REG_SRC_W, REG_SRC_H, REG_OUT_W,
            REG_OUT_H, REG_ORG_X, REG_ORG_Y: cfg_hit = i_cfg_we;
            default:                         cfg_hit = 1'b0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= SIZE_W'(1);
            r_src_h     <= SIZE_W'(1);
            r_out_w     <= OUT_W'(1);
            r_out_h     <= OUT_W'(1);
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= cfg_hit;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_SRC_W: r_src_w <= i_cfg_wdata[SIZE_W-1:0];
                    REG_SRC_H: r_src_h <= i_cfg_wdata[SIZE_W-1:0];
                    REG_OUT_W: r_out_w <= i_cfg_wdata;
                    REG_OUT_H: r_out_h <= i_cfg_wdata;
                    REG_ORG_X: r_org_x <= i_cfg_wdata;
                    REG_ORG_Y: r_org_y <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Clamp sizes: zero counts as one, source sizes saturate at the store size
    always_comb begin
        if (r_src_w == '0) begin
            geom.src_w = SW_W'(1);
        end else if (32'(r_src_w) > MAX_SRC_W) begin
            geom.src_w = SW_W'(MAX_SRC_W);
        end else begin
            geom.src_w = SW_W'(r_src_w);
        end
        if (r_src_h == '0) begin
            geom.src_h = SH_W'(1);
        end else if (32'(r_src_h) > MAX_SRC_H) begin
            geom.src_h = SH_W'(MAX_SRC_H);
        end else begin
            geom.src_h = SH_W'(r_src_h);
        end
        geom.out_w = (r_out_w == '0) ? OUT_W'(1) : r_out_w;
        geom.out_h = (r_out_h == '0) ? OUT_W'(1) : r_out_h;
        geom.org_x = r_org_x;
        geom.org_y = r_org_y;
    end

    // Fixed-point steps
    nnis_div u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (STEP_W'(geom.src_w) << FRAC_BITS),
        .i_divisor  (geom.out_w),
        .o_busy     (col_busy),
        .o_quot     (col_step)
    );

    nnis_div u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (STEP_W'(geom.src_h) << FRAC_BITS),
        .i_divisor  (geom.out_h),
        .o_busy     (row_busy),
        .o_quot     (row_step)
    );

    // Hold off input while steps are stale
    assign hold = r_div_start || col_busy || row_busy;

    nnis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg_hit),
        .i_hold     (hold),
        .i_geom     (geom),
        .i_col_step (col_step),
        .i_row_step (row_step),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_op       (front_op)
    );

    nnis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_full  (full),
        .o_empty (empty)
    );

    nnis_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_valid    (!empty),
        .i_op       (queue_op),
        .o_pop      (pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[sv/nnis_div.sv]
// Restoring divider, one quotient bit per cycle, for the fixed-point steps.
// Depends on nnis_pkg for widths and the fixed-point format.
`default_nettype none

module nnis_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [nnis_pkg::STEP_W-1:0] i_dividend,
    input  wire logic [nnis_pkg::OUT_W-1:0]  i_divisor,
    output logic                             o_busy,
    output logic [nnis_pkg::STEP_W-1:0]      o_quot
);
    import nnis_pkg::*;

    logic [STEP_W-1:0]    r_q, n_q;
    logic [OUT_W:0]       r_rem, n_rem;
    logic [OUT_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [OUT_W:0]       trial;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb begin
        trial = {r_rem[OUT_W-1:0], r_q[STEP_W-1]};
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_q   = i_dividend;
            n_rem = '0;
            n_cnt = DIV_CNT_W'(STEP_W);
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial - {1'b0, r_dvs};
                n_q   = {r_q[STEP_W-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_q   = {r_q[STEP_W-2:0], 1'b0};
            end
        end
    end

    // Quotient resets to the step of a one-pixel source over a one-pixel output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= STEP_W'(1) << FRAC_BITS;
            r_cnt <= '0;
        end else begin
            r_q   <= n_q;
            r_cnt <= n_cnt;
        end
    end

    // Hold divisor and remainder
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

endmodule

`default_nettype wire

[sv/nnis_front.sv]
// Front end: accepts stream beats, classifies loads and emits, and walks the
// output raster with incremental fixed-point source coordinates.
// Depends on nnis_pkg.
`default_nettype none

module nnis_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_restart,
    input  wire logic                           i_hold,
    input  wire nnis_pkg::t_geom                i_geom,
    input  wire logic [nnis_pkg::STEP_W-1:0]    i_col_step,
    input  wire logic [nnis_pkg::STEP_W-1:0]    i_row_step,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [nnis_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                           i_s_tuser,
    input  wire logic                           i_full,
    output logic                                o_push,
    output nnis_pkg::t_op                       o_op
);
    import nnis_pkg::*;

    logic [OUT_W-1:0] r_col, n_col;
    logic [OUT_W-1:0] r_row, n_row;
    logic [ACC_W-1:0] r_col_acc, n_col_acc;
    logic [ACC_W-1:0] r_row_acc, n_row_acc;

    logic             accept;
    logic             emit;
    logic             last_col;
    logic             last_row;
    logic [INT_W-1:0] sx_int;
    logic [INT_W-1:0] sy_int;
    logic [SW_W-1:0]  sx_max;
    logic [SH_W-1:0]  sy_max;
    t_req             kind;

    assign kind       = t_req'(i_s_tuser);
    assign o_s_tready = !i_full && !i_hold;
    assign accept     = i_s_tvalid && o_s_tready;
    assign emit       = accept && (kind == REQ_EMIT);
    assign o_push     = accept;

    // Classify the beat and build the queue entry
    always_comb begin
        last_col = (r_col == i_geom.out_w - 1'b1);
        last_row = (r_row == i_geom.out_h - 1'b1);
        sx_int   = r_col_acc[ACC_W-1:FRAC_BITS];
        sy_int   = r_row_acc[ACC_W-1:FRAC_BITS];
        sx_max   = i_geom.src_w - 1'b1;
        sy_max   = i_geom.src_h - 1'b1;

        o_op.kind  = kind;
        o_op.idx   = i_s_tdata[IDX_W-1:0];
        o_op.color = {i_s_tdata[IDX_W+2*CHAN_W +: CHAN_W],
                      i_s_tdata[IDX_W+CHAN_W   +: CHAN_W],
                      i_s_tdata[IDX_W          +: CHAN_W]};
        // Clamp to the last source column and row
        o_op.sx = (sx_int > INT_W'(sx_max)) ? SX_W'(sx_max) : SX_W'(sx_int);
        o_op.sy = (sy_int > INT_W'(sy_max)) ? SY_W'(sy_max) : SY_W'(sy_int);
        o_op.dest_x = DEST_W'(i_geom.org_x) + DEST_W'(r_col);
        o_op.dest_y = DEST_W'(i_geom.org_y) + DEST_W'(r_row);
        o_op.last   = last_col && last_row;
    end

    // Advance the raster position and the scaled coordinates
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_col_acc = r_col_acc;
        n_row_acc = r_row_acc;
        if (i_restart) begin
            n_col     = '0;
            n_row     = '0;
            n_col_acc = '0;
            n_row_acc = '0;
        end else if (emit) begin
            if (last_col) begin
                n_col     = '0;
                n_col_acc = '0;
                if (last_row) begin
                    n_row     = '0;
                    n_row_acc = '0;
                end else begin
                    n_row     = r_row + 1'b1;
                    n_row_acc = r_row_acc + ACC_W'(i_row_step);
                end
            end else begin
                n_col     = r_col + 1'b1;
                n_col_acc = r_col_acc + ACC_W'(i_col_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_acc <= '0;
            r_row_acc <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_col_acc <= n_col_acc;
            r_row_acc <= n_row_acc;
        end
    end

endmodule

`default_nettype wire

[sv/nnis_fifo.sv]
// Short queue of classified operations between the front and the back end.
// Depends on nnis_pkg for the entry type and depth.
`default_nettype none

module nnis_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire nnis_pkg::t_op i_op,
    input  wire logic          i_pop,
    output nnis_pkg::t_op      o_op,
    output logic               o_full,
    output logic               o_empty
);
    import nnis_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

[sv/nnis_back.sv]
// Back end: computes the flipped store address, writes loaded pixels, reads
// emitted ones and drives the output beat. Depends on nnis_pkg.
`default_nettype none

module nnis_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire nnis_pkg::t_geom                i_geom,
    input  wire logic                           i_valid,
    input  wire nnis_pkg::t_op                  i_op,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [nnis_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);
    import nnis_pkg::*;

    logic [COLOR_W-1:0] r_store [STORE_DEPTH];

    // Address stage
    logic               r_a_valid;
    t_req               r_a_kind;
    logic               r_a_wen;
    logic [ADDR_W-1:0]  r_a_addr;
    logic [COLOR_W-1:0] r_a_wdata;
    logic [DEST_W-1:0]  r_a_dest_x;
    logic [DEST_W-1:0]  r_a_dest_y;
    logic               r_a_last;

    // Read / output stage
    logic               r_b_valid;
    logic [COLOR_W-1:0] r_b_color;
    logic [DEST_W-1:0]  r_b_dest_x;
    logic [DEST_W-1:0]  r_b_dest_y;
    logic               r_b_last;

    logic               advance;
    logic [SY_W-1:0]    flip_y;
    logic [ADDR_W-1:0]  n_a_addr;
    logic               n_a_wen;

    assign advance = !r_b_valid || i_m_tready;
    assign o_pop   = advance && i_valid;

    // Flip the row for the bottom-up store and form the address
    always_comb begin
        flip_y  = SY_W'(i_geom.src_h - 1'b1) - i_op.sy;
        n_a_wen = (32'(i_op.idx) < STORE_DEPTH);
        if (i_op.kind == REQ_LOAD) begin
            n_a_addr = ADDR_W'(i_op.idx);
        end else begin
            n_a_addr = ADDR_W'(flip_y) * ADDR_W'(i_geom.src_w) + ADDR_W'(i_op.sx);
        end
    end

    // Advance both stages together when the output can move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid && (r_a_kind == REQ_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_kind   <= i_op.kind;
            r_a_wen    <= n_a_wen;
            r_a_addr   <= n_a_addr;
            r_a_wdata  <= i_op.color;
            r_a_dest_x <= i_op.dest_x;
            r_a_dest_y <= i_op.dest_y;
            r_a_last   <= i_op.last;
            r_b_dest_x <= r_a_dest_x;
            r_b_dest_y <= r_a_dest_y;
            r_b_last   <= r_a_last;
        end
    end

    // Pixel store: write on loads, registered read on emits
    always_ff @(posedge i_clk) begin
        if (advance && r_a_valid) begin
            if (r_a_kind == REQ_LOAD) begin
                if (r_a_wen) begin
                    r_store[r_a_addr] <= r_a_wdata;
                end
            end else begin
                r_b_color <= r_store[r_a_addr];
            end
        end
    end

    // Pack the output beat
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[0 +: DEST_W]        = r_b_dest_x;
        o_m_tdata[DEST_W +: DEST_W]   = r_b_dest_y;
        o_m_tdata[2*DEST_W +: COLOR_W] = r_b_color;
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tlast  = r_b_last;

endmodule

`default_nettype wire
